// ===== rtl/ckpd_pkg.sv =====
// Shared types and constants of the colour-keyed point detector.
package ckpd_pkg;

  // Fixed field widths.
  localparam int unsigned CoordBits = 11;
  localparam int unsigned SampleBits = 16;
  localparam int unsigned KeyBits = 24;
  localparam int unsigned ThreshBits = 11;
  localparam int unsigned ColEndBits = 12;
  localparam int unsigned TypeBits = 2;
  localparam int unsigned IndexBits = 6;
  localparam int unsigned CfgIndexBits = 3;

  // Depth of the queue between the classifier and the table engine.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrBits = 2;
  localparam int unsigned QueueCntBits = 3;

  // Configuration register indices.
  typedef enum logic [CfgIndexBits-1:0] {
    CfgKeyColorA    = 3'd0,
    CfgKeyColorB    = 3'd1,
    CfgKeyColorC    = 3'd2,
    CfgNearThresh   = 3'd3,
    CfgColStart     = 3'd4,
    CfgColEnd       = 3'd5
  } cfg_index_e;

  // Reset values of the configuration registers.
  localparam logic [KeyBits-1:0]    KeyColorAReset = 24'hEF1234;
  localparam logic [KeyBits-1:0]    KeyColorBReset = 24'hABCD12;
  localparam logic [KeyBits-1:0]    KeyColorCReset = 24'h123ABC;
  localparam logic [ThreshBits-1:0] NearThreshReset = 11'd25;
  localparam logic [CoordBits-1:0]  ColStartReset = 11'd0;
  localparam logic [ColEndBits-1:0] ColEndReset = 12'd2048;

  // Point types.
  localparam logic [TypeBits-1:0] TypeA = 2'd0;
  localparam logic [TypeBits-1:0] TypeB = 2'd1;
  localparam logic [TypeBits-1:0] TypeC = 2'd2;

  // Input request.
  typedef struct packed {
    logic [CoordBits-1:0]  pixel_x;
    logic [CoordBits-1:0]  pixel_y;
    logic [SampleBits-1:0] red;
    logic [SampleBits-1:0] green;
    logic [SampleBits-1:0] blue;
    logic                  last_pixel;
  } pixel_t;

  // Output request.
  typedef struct packed {
    logic [CoordBits-1:0] point_x;
    logic [CoordBits-1:0] point_y;
    logic [TypeBits-1:0]  point_type;
    logic [IndexBits-1:0] point_index;
    logic                 dropped;
  } point_t;

  // Live configuration.
  typedef struct packed {
    logic [KeyBits-1:0]    key_color_a;
    logic [KeyBits-1:0]    key_color_b;
    logic [KeyBits-1:0]    key_color_c;
    logic [ThreshBits-1:0] near_threshold;
    logic [CoordBits-1:0]  col_start;
    logic [ColEndBits-1:0] col_end;
  } cfg_t;

  // Classified pixel as queued for the table engine.
  typedef struct packed {
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [TypeBits-1:0]  ptype;
    logic                 hit;
    logic                 last;
  } item_t;

  // Queue status seen by the table engine.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

endpackage

// ===== rtl/ckpd_front.sv =====
// Front end: column window check and key colour classification.
module ckpd_front (
  input  ckpd_pkg::pixel_t in_data_i,
  input  logic             in_valid_i,
  input  ckpd_pkg::cfg_t   cfg_i,
  input  logic             q_full_i,
  output logic             in_stall_o,
  output logic             q_push_o,
  output ckpd_pkg::item_t  q_item_o
);

  logic       in_window;
  logic       hit_a;
  logic       hit_b;
  logic       hit_c;
  logic [7:0] r8;
  logic [7:0] g8;
  logic [7:0] b8;

  // Top byte of each channel is what the keys compare against.
  assign r8 = in_data_i.red[15:8];
  assign g8 = in_data_i.green[15:8];
  assign b8 = in_data_i.blue[15:8];

  assign in_window = (in_data_i.pixel_x >= cfg_i.col_start) &&
                     ({1'b0, in_data_i.pixel_x} < cfg_i.col_end);

  assign hit_a = (cfg_i.key_color_a == {r8, g8, b8});
  assign hit_b = (cfg_i.key_color_b == {r8, g8, b8});
  assign hit_c = (cfg_i.key_color_c == {r8, g8, b8});

  // The first matching key wins.
  always_comb begin
    q_item_o.x = in_data_i.pixel_x;
    q_item_o.y = in_data_i.pixel_y;
    q_item_o.last = in_data_i.last_pixel;
    q_item_o.hit = in_window && (hit_a || hit_b || hit_c);
    if (hit_a) begin
      q_item_o.ptype = ckpd_pkg::TypeA;
    end else if (hit_b) begin
      q_item_o.ptype = ckpd_pkg::TypeB;
    end else begin
      q_item_o.ptype = ckpd_pkg::TypeC;
    end
  end

  // Only matches and frame ends have anything for the back end to do.
  assign in_stall_o = q_full_i;
  assign q_push_o = in_valid_i && !q_full_i && (q_item_o.hit || q_item_o.last);

endmodule

// ===== rtl/ckpd_fifo.sv =====
// Short queue between the classifier and the table engine.
module ckpd_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ckpd_pkg::item_t       item_i,
  input  logic                  pop_i,
  output logic                  full_o,
  output ckpd_pkg::queue_out_t  q_o
);

  ckpd_pkg::item_t                       mem_q [ckpd_pkg::QueueDepth];
  logic [ckpd_pkg::QueuePtrBits-1:0]     wr_ptr_q, wr_ptr_d;
  logic [ckpd_pkg::QueuePtrBits-1:0]     rd_ptr_q, rd_ptr_d;
  logic [ckpd_pkg::QueueCntBits-1:0]     cnt_q, cnt_d;
  logic                                  do_push;
  logic                                  do_pop;

  assign full_o = (cnt_q == ckpd_pkg::QueueCntBits'(ckpd_pkg::QueueDepth));
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && (cnt_q != '0);

  assign q_o.valid = (cnt_q != '0);
  assign q_o.item = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/ckpd_back.sv =====
// Back end: point table scan, insertion and result register.
module ckpd_back #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ckpd_pkg::cfg_t       cfg_i,
  input  ckpd_pkg::queue_out_t q_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ckpd_pkg::point_t     out_data_o
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned EW = 2 * ckpd_pkg::CoordBits;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StEmit = 3'b100
  } state_e;

  state_e                       state_q, state_d;
  ckpd_pkg::item_t              cur_q, cur_d;
  logic [CW-1:0]                count_q, count_d;
  logic [CW-1:0]                scan_q, scan_d;
  logic                         pend_q, pend_d;
  logic                         out_valid_q, out_valid_d;
  ckpd_pkg::point_t             out_data_q, out_data_d;
  logic [EW-1:0]                tbl_mem [MAX_POINTS];
  logic [EW-1:0]                rd_q;
  logic                         tbl_we;
  logic                         full;
  logic                         near_hit;
  logic [ckpd_pkg::CoordBits-1:0] rd_x, rd_y, dx, dy;

  assign full = (count_q == CW'(MAX_POINTS));
  assign rd_x = rd_q[EW-1:ckpd_pkg::CoordBits];
  assign rd_y = rd_q[ckpd_pkg::CoordBits-1:0];

  // Per-axis distance to the entry read last cycle.
  assign dx = (cur_q.x > rd_x) ? cur_q.x - rd_x : rd_x - cur_q.x;
  assign dy = (cur_q.y > rd_y) ? cur_q.y - rd_y : rd_y - cur_q.y;
  assign near_hit = pend_q && (dx <= cfg_i.near_threshold) &&
                    (dy <= cfg_i.near_threshold);

  // Sequencer: take an item, scan stored points, then emit or discard.
  always_comb begin
    state_d = state_q;
    cur_d = cur_q;
    count_d = count_q;
    scan_d = scan_q;
    pend_d = 1'b0;
    q_pop_o = 1'b0;
    tbl_we = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d = out_data_q;
    case (state_q)
      StIdle: begin
        if (q_i.valid) begin
          q_pop_o = 1'b1;
          cur_d = q_i.item;
          if (q_i.item.hit) begin
            scan_d = '0;
            state_d = StScan;
          end else if (q_i.item.last) begin
            count_d = '0;
          end
        end
      end
      StScan: begin
        if (near_hit) begin
          // Close to an existing point: nothing to report.
          state_d = StIdle;
          if (cur_q.last) begin
            count_d = '0;
          end
        end else if (scan_q == count_q && !pend_q) begin
          state_d = StEmit;
        end else if (scan_q != count_q) begin
          pend_d = 1'b1;
          scan_d = scan_q + 1'b1;
        end
      end
      StEmit: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d.point_x = cur_q.x;
          out_data_d.point_y = cur_q.y;
          out_data_d.point_type = cur_q.ptype;
          if (full) begin
            out_data_d.point_index = '0;
            out_data_d.dropped = 1'b1;
            count_d = count_q;
          end else begin
            out_data_d.point_index = ckpd_pkg::IndexBits'(count_q);
            out_data_d.dropped = 1'b0;
            tbl_we = 1'b1;
            count_d = count_q + 1'b1;
          end
          if (cur_q.last) begin
            count_d = '0;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      scan_q <= '0;
      pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      scan_q <= scan_d;
      pend_q <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_data_q <= out_data_d;
  end

  // Point table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[count_q[AW-1:0]] <= {cur_q.x, cur_q.y};
    end
    rd_q <= tbl_mem[scan_q[AW-1:0]];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;

endmodule

// ===== rtl/color_key_point_dedup.sv =====
// Top level of the colour-keyed point detector with proximity merging.
//
// Pixels inside the column window whose top colour bytes equal one of three
// keys become points, unless a stored point lies within the threshold on
// both axes. The front end takes one pixel per cycle while the queue has room
// and places matching pixels and frame ends in a four-entry queue; pixels that
// neither match nor end a frame go no further. The back end works on one
// queued item at a time: a match is compared with each point stored so far
// in the frame, read one entry per cycle through the table's single read
// port. A match that lands near a stored point finishes with no result.
// Emitting waits while an earlier result is still held by a stalled receiver.
// The table needs no clearing pass: a fill count marks which entries are
// valid and is zeroed after each frame's last pixel. When the table is full
// a new point is reported with dropped set and slot zero. Configuration may
// only be written while the block is idle.
module color_key_point_dedup #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  ckpd_pkg::pixel_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ckpd_pkg::point_t                    out_data_o,
  input  logic                                cfg_we_i,
  input  logic [ckpd_pkg::CfgIndexBits-1:0]   cfg_index_i,
  input  logic [ckpd_pkg::KeyBits-1:0]        cfg_wdata_i
);

  ckpd_pkg::cfg_t       cfg_q;
  ckpd_pkg::item_t      push_item;
  ckpd_pkg::queue_out_t q_out;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_full;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_color_a <= ckpd_pkg::KeyColorAReset;
      cfg_q.key_color_b <= ckpd_pkg::KeyColorBReset;
      cfg_q.key_color_c <= ckpd_pkg::KeyColorCReset;
      cfg_q.near_threshold <= ckpd_pkg::NearThreshReset;
      cfg_q.col_start <= ckpd_pkg::ColStartReset;
      cfg_q.col_end <= ckpd_pkg::ColEndReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ckpd_pkg::CfgKeyColorA: cfg_q.key_color_a <= cfg_wdata_i;
        ckpd_pkg::CfgKeyColorB: cfg_q.key_color_b <= cfg_wdata_i;
        ckpd_pkg::CfgKeyColorC: cfg_q.key_color_c <= cfg_wdata_i;
        ckpd_pkg::CfgNearThresh: begin
          cfg_q.near_threshold <= cfg_wdata_i[ckpd_pkg::ThreshBits-1:0];
        end
        ckpd_pkg::CfgColStart: begin
          cfg_q.col_start <= cfg_wdata_i[ckpd_pkg::CoordBits-1:0];
        end
        ckpd_pkg::CfgColEnd: begin
          cfg_q.col_end <= cfg_wdata_i[ckpd_pkg::ColEndBits-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Classifier.
  ckpd_front u_front (
    .in_data_i  (in_data_i),
    .in_valid_i (in_valid_i),
    .cfg_i      (cfg_q),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .q_push_o   (q_push),
    .q_item_o   (push_item)
  );

  // Decoupling queue.
  ckpd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (push_item),
    .pop_i  (q_pop),
    .full_o (q_full),
    .q_o    (q_out)
  );

  // Table engine.
  ckpd_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_i         (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTH
  // A dropped point never claims a table slot.
  a_drop_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.dropped |-> out_data_o.point_index == '0)
    else $error("dropped point carries a slot index");

  // Only the three key types are ever reported.
  a_type_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.point_type != 2'd3)
    else $error("reported point type out of range");

  // The table engine never takes from an empty queue.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_out.valid)
    else $error("queue popped while empty");

  // A queued request is never lost to a full queue.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("queue pushed while full");
`endif

endmodule
